### rtl/psrl_pkg.sv
// shared types, constants and codes for the per-source rate limit table
`default_nettype none

package psrl_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam int MODE_W    = 3;
  localparam int IP_W      = 32;
  localparam int VERDICT_W = 2;
  localparam int TOTAL_W   = 32;
  localparam int CFG_W     = 16;
  localparam int SEC_W     = 32;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [CFG_W-1:0] RPS_RESET   = CFG_W'(100);
  localparam logic [CFG_W-1:0] BURST_RESET = CFG_W'(200);
  localparam logic [CFG_W-1:0] CONN_RESET  = CFG_W'(10);
  localparam logic [CFG_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_CHECK   = 3'd1,
    MODE_CONNECT = 3'd2,
    MODE_BLOCK   = 3'd3,
    MODE_UNBLOCK = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_OK      = 2'd0,
    V_LIMITED = 2'd1,
    V_BLOCKED = 2'd2,
    V_FAILED  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMITED = 2'd1,
    ST_BLOCKED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_RPS   = 2'd0,
    REG_BURST = 2'd1,
    REG_CONN  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]  address;
    status_t          status;
    logic [SEC_W-1:0] window_start;
    logic [CFG_W-1:0] req_count;
    logic [CFG_W-1:0] conn_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### rtl/psrl_if.sv
// request and response channel interfaces
`default_nettype none

interface psrl_req_if import psrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IP_W-1:0]   src_addr;

  modport source (output valid, mode, src_addr, input ready);
  modport sink (input valid, mode, src_addr, output ready);
endinterface

interface psrl_rsp_if import psrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [TOTAL_W-1:0]   violation_total;
  logic [TOTAL_W-1:0]   flood_total;
  logic [TOTAL_W-1:0]   blocked_total;

  modport source (output valid, verdict, violation_total, flood_total, blocked_total,
                  input ready);
  modport sink (input valid, verdict, violation_total, flood_total, blocked_total,
                output ready);
endinterface

`default_nettype wire

### rtl/psrl_ram.sv
// generic single write port ram with registered read
`default_nettype none

module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/per_source_rate_limit_table_core.sv
// Per-source fixed-window rate limiter: a table of client entries keyed by IPv4 address,
// held in one entry RAM that a small sequencer searches one entry per cycle. Entries fill
// from slot 0 upwards and are never freed, so a fill count stands in for per-entry valid
// bits and no clearing pass is needed after reset. A table operation scans the filled
// entries in order and stops early when the client is found; a tick or an unused mode
// skips the scan. The scan rate is set by the single read port of the entry RAM. The
// block takes one transaction at a time and holds its result in an output register until
// it is taken; a result not yet taken holds the next one in its update step.
// Configuration registers sit behind an APB port at byte offsets 0, 4 and 8.
`default_nettype none

module per_source_rate_limit_table_core import psrl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  psrl_req_if.sink               req,
  psrl_rsp_if.source             rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  state_t state, state_next;

  logic [MODE_W-1:0] op_mode;
  logic [IP_W-1:0]   op_ip;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] scan_idx;
  logic              cmp_pending;
  logic [IDX_W-1:0]  cmp_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  entry_t            ent;

  logic [SEC_W-1:0]   seconds, seconds_next;
  logic [TOTAL_W-1:0] viol, viol_next;
  logic [TOTAL_W-1:0] flood, flood_next;
  logic [TOTAL_W-1:0] blk, blk_next;

  logic [CFG_W-1:0] rps;
  logic [CFG_W-1:0] burst;
  logic [CFG_W-1:0] conn_ceil;

  logic     out_valid;
  verdict_t out_verdict;

  entry_t rd_entry;
  entry_t upd;
  logic   match;
  logic   scan_done;
  logic   issue;
  logic   commit;
  logic   write_en;
  logic   has_entry;
  logic   room;
  logic   accept;
  verdict_t verdict;

  logic [CFG_W-1:0] cnt0;
  logic [CFG_W-1:0] cnt1;

  psrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_psrl_ram (
    .clk   (clk),
    .we    (commit && write_en),
    .waddr (hit_idx),
    .wdata (upd),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // search status
  assign match     = (state == S_SCAN) && cmp_pending && (rd_entry.address == op_ip);
  assign scan_done = (state == S_SCAN) && !match && !cmp_pending && (scan_idx == fill);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode inside {MODE_CHECK, MODE_CONNECT, MODE_BLOCK, MODE_UNBLOCK,
                               MODE_QUERY}) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_SCAN: begin
        if (match || scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = (state == S_IDLE);
    accept    = req.valid && (state == S_IDLE);
    issue     = (state == S_SCAN) && !match && (scan_idx < fill);
    commit    = (state == S_UPDATE) && (!out_valid || rsp.ready);
  end

  // entry update and verdict
  always_comb begin
    room         = (fill != FILL_MAX);
    has_entry    = hit || (room && (op_mode inside {MODE_CHECK, MODE_CONNECT, MODE_BLOCK}));
    upd          = ent;
    verdict      = V_OK;
    write_en     = 1'b0;
    seconds_next = seconds;
    viol_next    = viol;
    flood_next   = flood;
    blk_next     = blk;
    cnt0         = (seconds != ent.window_start) ? '0 : ent.req_count;
    cnt1         = (cnt0 != COUNT_MAX) ? cnt0 + CFG_W'(1) : cnt0;
    case (op_mode)
      MODE_TICK: begin
        seconds_next = seconds + SEC_W'(1);
      end
      MODE_CHECK: begin
        if (has_entry) begin
          write_en         = 1'b1;
          upd.window_start = seconds;
          upd.req_count    = cnt1;
          if (cnt1 > rps) begin
            if (cnt1 > burst) begin
              upd.status = ST_BLOCKED;
              verdict    = V_BLOCKED;
              viol_next  = viol + TOTAL_W'(1);
            end else begin
              upd.status = ST_LIMITED;
              verdict    = V_LIMITED;
            end
          end else begin
            upd.status = ST_OK;
          end
        end
      end
      MODE_CONNECT: begin
        if (has_entry) begin
          write_en = 1'b1;
          if (ent.conn_count >= conn_ceil) begin
            flood_next = flood + TOTAL_W'(1);
            verdict    = V_BLOCKED;
          end else begin
            upd.conn_count = ent.conn_count + CFG_W'(1);
          end
        end
      end
      MODE_BLOCK: begin
        if (has_entry) begin
          write_en   = 1'b1;
          upd.status = ST_BLOCKED;
          blk_next   = blk + TOTAL_W'(1);
        end else begin
          verdict = V_FAILED;
        end
      end
      MODE_UNBLOCK: begin
        if (hit) begin
          write_en   = 1'b1;
          upd.status = ST_OK;
        end else begin
          verdict = V_FAILED;
        end
      end
      MODE_QUERY: begin
        if (hit && (ent.status == ST_BLOCKED)) begin
          verdict = V_BLOCKED;
        end
      end
      default: verdict = V_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      scan_idx    <= '0;
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
      seconds     <= '0;
      viol        <= '0;
      flood       <= '0;
      blk         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_idx    <= '0;
        cmp_pending <= 1'b0;
        hit         <= 1'b0;
      end else if (state == S_SCAN) begin
        cmp_pending <= issue;
        if (issue) begin
          scan_idx <= scan_idx + FILL_W'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (commit) begin
        seconds   <= seconds_next;
        viol      <= viol_next;
        flood     <= flood_next;
        blk       <= blk_next;
        out_valid <= 1'b1;
        if (write_en && !hit) begin
          fill <= fill + FILL_W'(1);
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= req.mode;
      op_ip   <= req.src_addr;
    end
    if (state == S_SCAN) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
      if (match) begin
        hit_idx <= cmp_idx;
        ent     <= rd_entry;
      end else if (scan_done) begin
        hit_idx <= fill[IDX_W-1:0];
        ent     <= '{address: op_ip, status: ST_OK, window_start: '0,
                     req_count: '0, conn_count: '0};
      end
    end
    if (commit) begin
      out_verdict <= verdict;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.verdict         = out_verdict;
  assign rsp.violation_total = viol;
  assign rsp.flood_total     = flood;
  assign rsp.blocked_total   = blk;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rps       <= RPS_RESET;
      burst     <= BURST_RESET;
      conn_ceil <= CONN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RPS:   rps       <= pwdata[CFG_W-1:0];
        REG_BURST: burst     <= pwdata[CFG_W-1:0];
        REG_CONN:  conn_ceil <= pwdata[CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RPS:   prdata = APB_DW'(rps);
      REG_BURST: prdata = APB_DW'(burst);
      REG_CONN:  prdata = APB_DW'(conn_ceil);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/psrl_checker.sv
// port-level checks for the rate limit table core, bound into the core module
`default_nettype none

module psrl_checker import psrl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [VERDICT_W-1:0] rsp_verdict,
  input wire logic [TOTAL_W-1:0]   rsp_violation_total,
  input wire logic [TOTAL_W-1:0]   rsp_flood_total,
  input wire logic [TOTAL_W-1:0]   rsp_blocked_total
);

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (req_ready && !rsp_valid))
    else $error("block not idle after reset");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready held after accepting a transaction");

  // a result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> req_ready)
    else $error("result raised while the sequencer is busy");

  // a stalled result and its totals hold
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict)
      && $stable(rsp_violation_total) && $stable(rsp_flood_total)
      && $stable(rsp_blocked_total)))
    else $error("stalled result changed");

endmodule

bind per_source_rate_limit_table_core psrl_checker u_psrl_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_verdict         (rsp.verdict),
  .rsp_violation_total (rsp.violation_total),
  .rsp_flood_total     (rsp.flood_total),
  .rsp_blocked_total   (rsp.blocked_total)
);

`default_nettype wire
